### hdl/sufp_pkg.sv
// Shared types and constants of the sensor UART frame parser.
package sufp_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned DistWidth     = 16;
   localparam int unsigned StatusWidth   = 2;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [ByteWidth-1:0] FrameHeader = 8'hFF;

   localparam logic [DistWidth-1:0] ResetMinDistance = 16'd30;
   localparam logic [DistWidth-1:0] ResetMaxDistance = 16'd7500;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrMinDistance = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxDistance = 1'd1;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_RANGE    = 2'd2
   } frame_status_type;

   // Position inside a frame, one-hot
   typedef enum logic [3:0] {
      POS_HUNT  = 4'b0001,
      POS_HIGH  = 4'b0010,
      POS_LOW   = 4'b0100,
      POS_CHECK = 4'b1000
   } frame_pos_type;

   typedef struct packed {
      logic [DistWidth-1:0] distance_mm;
      frame_status_type     frame_status;
   } frame_result_type;

   typedef struct packed {
      logic at_check;
   } core_status_type;

endpackage

### hdl/sufp_frame_core.sv
// Frame position tracking, byte capture and frame judgment.
module sufp_frame_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 byte_accept,
   input  logic [sufp_pkg::ByteWidth-1:0]       rx_byte,
   input  logic [sufp_pkg::DistWidth-1:0]       min_distance,
   input  logic [sufp_pkg::DistWidth-1:0]       max_distance,
   output sufp_pkg::core_status_type            core_status,
   output sufp_pkg::frame_result_type           frame_result
);

   sufp_pkg::frame_pos_type               pos_ff, pos_in;
   logic [sufp_pkg::ByteWidth-1:0]        high_ff, high_in;
   logic [sufp_pkg::ByteWidth-1:0]        low_ff, low_in;
   logic [sufp_pkg::ByteWidth-1:0]        sum;
   logic [sufp_pkg::DistWidth-1:0]        distance;

   // Advance the frame position on each accepted byte
   always_comb begin
      pos_in  = pos_ff;
      high_in = high_ff;
      low_in  = low_ff;
      if (byte_accept) begin
         case (pos_ff)
            sufp_pkg::POS_HUNT: begin
               if (rx_byte == sufp_pkg::FrameHeader) begin
                  pos_in = sufp_pkg::POS_HIGH;
               end
            end
            sufp_pkg::POS_HIGH: begin
               high_in = rx_byte;
               pos_in  = sufp_pkg::POS_LOW;
            end
            sufp_pkg::POS_LOW: begin
               low_in = rx_byte;
               pos_in = sufp_pkg::POS_CHECK;
            end
            sufp_pkg::POS_CHECK: begin
               pos_in = sufp_pkg::POS_HUNT;
            end
            default: begin
               pos_in = sufp_pkg::POS_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= sufp_pkg::POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Hold the captured distance bytes
   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   // Judge the frame against the checksum byte and the range
   assign distance = {high_ff, low_ff};
   assign sum      = sufp_pkg::FrameHeader + high_ff + low_ff;

   always_comb begin
      frame_result.distance_mm = distance;
      if (sum != rx_byte) begin
         frame_result.frame_status = sufp_pkg::STATUS_CHECKSUM;
      end else if ((distance < min_distance) || (distance > max_distance)) begin
         frame_result.frame_status = sufp_pkg::STATUS_RANGE;
      end else begin
         frame_result.frame_status = sufp_pkg::STATUS_VALID;
      end
   end

   assign core_status.at_check = (pos_ff == sufp_pkg::POS_CHECK);

endmodule

### hdl/sensor_uart_frame_parser_unit.sv
// Top level of the sensor UART frame parser.
//
// Request channel (req_valid/req_ready/req_rx_byte) carries one received
// serial byte per request. Bytes before a 0xFF header are dropped; after a
// header come distance high byte, low byte and checksum byte.
// Response channel (rsp_valid/rsp_ready) carries one result per frame:
// rsp_distance_mm and rsp_frame_status (0 valid, 1 checksum error,
// 2 out of range). It appears in the cycle after the checksum byte is taken.
// Throughput is one byte per cycle unless the checksum byte stalls; the
// output register holds one result. Header, high and low bytes are taken
// even while a result waits; the checksum byte is taken once the output
// register is empty or is being read in the same cycle.
// Configuration port (csr_valid/csr_ready/csr_index/csr_data) writes
// min_distance (index 0) and max_distance (index 1); always ready.
// Reset (synchronous) returns to header hunting, empties the output
// register and loads the range limits 30 and 7500.
module sensor_uart_frame_parser_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sufp_pkg::ByteWidth-1:0]        req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sufp_pkg::DistWidth-1:0]        rsp_distance_mm,
   output logic [sufp_pkg::StatusWidth-1:0]      rsp_frame_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sufp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [sufp_pkg::DistWidth-1:0]        csr_data
);

   logic [sufp_pkg::DistWidth-1:0]   min_ff, max_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   sufp_pkg::frame_result_type       result_ff, result_in;
   sufp_pkg::core_status_type        core_status;
   sufp_pkg::frame_result_type       frame_result;
   logic                             req_accept;
   logic                             fire;

   // Write range registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= sufp_pkg::ResetMinDistance;
         max_ff <= sufp_pkg::ResetMaxDistance;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sufp_pkg::CsrMinDistance: min_ff <= csr_data;
            sufp_pkg::CsrMaxDistance: max_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Stall only the checksum byte while the output register is full and not being read
   assign req_ready  = !core_status.at_check || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign fire       = req_accept && core_status.at_check;

   sufp_frame_core u_core (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (req_accept),
      .rx_byte      (req_rx_byte),
      .min_distance (min_ff),
      .max_distance (max_ff),
      .core_status  (core_status),
      .frame_result (frame_result)
   );

   // Load the result register on a finished frame, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         result_in    = frame_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_mm  = result_ff.distance_mm;
   assign rsp_frame_status = result_ff.frame_status;

endmodule

### hdl/sufp_checker.sv
// Port-level checks for the sensor UART frame parser, bound to the top level.
module sufp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [sufp_pkg::DistWidth-1:0]       rsp_distance_mm,
   input logic [sufp_pkg::StatusWidth-1:0]     rsp_frame_status
);

   // Empty the output register at reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_mm)
         && $stable(rsp_frame_status))
      else $error("stalled response changed");

   // Report only defined status codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_status == sufp_pkg::STATUS_VALID)
         || (rsp_frame_status == sufp_pkg::STATUS_CHECKSUM)
         || (rsp_frame_status == sufp_pkg::STATUS_RANGE))
      else $error("undefined frame status");

   // Raise a response only after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response without request");

endmodule

bind sensor_uart_frame_parser_unit sufp_checker u_sufp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_distance_mm  (rsp_distance_mm),
   .rsp_frame_status (rsp_frame_status)
);
